// ----- hw/rtl/fgst_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Feed group sequence gap tracker package
// Shared widths, codes and record types of the gap tracker.
// ----------------------------------------------------------------------------
package fgst_pkg;

	localparam int GROUP_W          = 8;
	localparam int SEQ_W            = 64;
	localparam int LIMIT_W          = 8;
	localparam int NUM_GROUPS_DEF   = 255;
	localparam int QUEUE_DEPTH      = 4;
	localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);
	localparam int IN_DATA_W        = 144;
	localparam int IN_USER_W        = 2;
	localparam int OUT_DATA_W       = 152;

	localparam logic [GROUP_W-1:0] GROUP_UNKNOWN   = 8'hFF;
	localparam logic [LIMIT_W-1:0] GAP_LIMIT_RESET = 8'hFF;
	localparam logic [LIMIT_W-1:0] GAP_COUNT_MAX   = 8'hFF;

	typedef enum logic [1:0] {
		MODE_INIT   = 2'd0,
		MODE_NORMAL = 2'd1,
		MODE_SNAP   = 2'd2,
		MODE_RETX   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ACT_DISCARD = 2'd0,
		ACT_PROCESS = 2'd1,
		ACT_QUEUE   = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		EV_NONE      = 3'd0,
		EV_DOWN_INIT = 3'd1,
		EV_DOWN      = 3'd2,
		EV_UP_INIT   = 3'd3,
		EV_UP        = 3'd4
	} event_t;

	typedef enum logic {
		OP_PACKET   = 1'b0,
		OP_RECOVERY = 1'b1
	} op_t;

	typedef struct packed {
		op_t              operation;
		logic [GROUP_W-1:0] group_id;
		logic [SEQ_W-1:0] sequence_req;
		logic             is_heartbeat;
		logic             in_trading_hours;
		logic [SEQ_W-1:0] resume_sequence;
	} in_beat_t;

	typedef struct packed {
		op_t              operation;
		logic [GROUP_W-1:0] group_id;
		logic             grp_ok;
		logic [SEQ_W-1:0] seq;
		logic [SEQ_W-1:0] seq_inc;
		logic [SEQ_W-1:0] seq_dec;
		logic             heartbeat;
		logic             trading;
		logic [SEQ_W-1:0] resume;
	} item_t;

	typedef struct packed {
		mode_t            mode;
		logic [SEQ_W-1:0] expected;
		logic [SEQ_W-1:0] snap_next;
		logic             done;
		logic [LIMIT_W-1:0] count;
	} grp_state_t;

	typedef struct packed {
		logic [GROUP_W-1:0] out_group;
		action_t          packet_action;
		event_t           feed_event;
		logic             progressing_up;
		logic             back_in_time;
		logic             recovery_request;
		logic [SEQ_W-1:0] recovery_first;
		logic [SEQ_W-1:0] recovery_last;
		logic             snapshot_image;
		logic             after_gap;
	} result_t;

endpackage
`default_nettype wire

// ----- hw/rtl/fgst_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Gap tracker front end
// Accepts input beats, checks the group and precomputes the neighbor
// sequence numbers before handing the item to the queue.
// ----------------------------------------------------------------------------
module fgst_front #(
	parameter int NUM_GROUPS = fgst_pkg::NUM_GROUPS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  fgst_pkg::in_beat_t  in_beat,
	output logic                push,
	input  wire                 q_full,
	output fgst_pkg::item_t     push_item
);
	import fgst_pkg::*;

	logic    vld_s1;
	item_t   item_s1;
	logic    load;

	assign in_ready  = !vld_s1 || !q_full;
	assign load      = in_valid && in_ready;
	assign push      = vld_s1 && !q_full;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (load) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.operation <= in_beat.operation;
			item_s1.group_id  <= in_beat.group_id;
			item_s1.grp_ok    <= (in_beat.group_id != GROUP_UNKNOWN) &&
				(in_beat.group_id < GROUP_W'(NUM_GROUPS));
			item_s1.seq       <= in_beat.sequence_req;
			item_s1.seq_inc   <= in_beat.sequence_req + SEQ_W'(1);
			item_s1.seq_dec   <= in_beat.sequence_req - SEQ_W'(1);
			item_s1.heartbeat <= in_beat.is_heartbeat;
			item_s1.trading   <= in_beat.in_trading_hours;
			item_s1.resume    <= in_beat.resume_sequence;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/fgst_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Gap tracker item queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module fgst_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  fgst_pkg::item_t  push_item,
	output logic             full,
	input  wire              pop,
	output logic             empty,
	output fgst_pkg::item_t  pop_item
);
	import fgst_pkg::*;

	item_t               buf_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 :
					wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 :
					rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/fgst_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Gap tracker back end
// Reads the group state, applies the mode rules, writes the state back and
// holds the finished result in an output register.
// ----------------------------------------------------------------------------
module fgst_back #(
	parameter int NUM_GROUPS = fgst_pkg::NUM_GROUPS_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire [fgst_pkg::LIMIT_W-1:0] gap_limit,
	input  wire                         q_empty,
	input  fgst_pkg::item_t             q_item,
	output logic                        pop,
	output logic                        out_valid,
	input  wire                         out_ready,
	output fgst_pkg::result_t           out_result
);
	import fgst_pkg::*;

	localparam int GIDX_W = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

	grp_state_t          mem [NUM_GROUPS];
	logic [NUM_GROUPS-1:0] written_q;
	grp_state_t          mem_rd_q;
	grp_state_t          byp_st_q;
	logic                byp_s2;
	logic                written_s2;
	logic                vld_s2;
	item_t               item_s2;
	logic                vld_s3;
	result_t             res_s3;

	logic [GIDX_W-1:0]   pop_idx;
	logic [GIDX_W-1:0]   idx_s2;
	logic                adv;
	logic                wr;
	grp_state_t          cur;
	grp_state_t          nxt;
	result_t             res;
	logic                seq_lt;
	logic                seq_gt;
	logic [LIMIT_W-1:0]  cnt_n;

	assign pop_idx = q_item.group_id[GIDX_W-1:0];
	assign idx_s2  = item_s2.group_id[GIDX_W-1:0];
	assign adv     = vld_s2 && (!vld_s3 || out_ready);
	assign pop     = !q_empty && (!vld_s2 || adv);
	assign wr      = adv && item_s2.grp_ok;

	assign cur = byp_s2 ? byp_st_q : (written_s2 ? mem_rd_q : '0);

	assign out_valid  = vld_s3;
	assign out_result = res_s3;

	always_comb begin
		nxt    = cur;
		res    = '0;
		res.out_group = item_s2.group_id;
		seq_lt = item_s2.seq < cur.expected;
		seq_gt = item_s2.seq > cur.expected;
		cnt_n  = (cur.count == GAP_COUNT_MAX) ? cur.count : cur.count + LIMIT_W'(1);
		if (item_s2.grp_ok) begin
			if (item_s2.operation == OP_RECOVERY) begin
				nxt.done      = 1'b1;
				nxt.snap_next = item_s2.resume;
			end else begin
				case (cur.mode)
					MODE_INIT: begin
						res.feed_event = EV_DOWN_INIT;
						if (item_s2.trading) begin
							nxt.done           = 1'b1;
							nxt.mode           = MODE_NORMAL;
							nxt.expected       = item_s2.seq_inc;
							res.progressing_up = 1'b1;
						end else begin
							nxt.done             = 1'b0;
							nxt.mode             = MODE_SNAP;
							res.packet_action    = ACT_QUEUE;
							res.recovery_request = 1'b1;
							res.recovery_first   = SEQ_W'(1);
							res.recovery_last    = item_s2.seq_dec;
						end
					end
					MODE_NORMAL: begin
						if (seq_lt && (cur.expected == cur.snap_next)) begin
							nxt = cur;
						end else if (seq_lt && !item_s2.heartbeat) begin
							res.back_in_time = 1'b1;
							nxt.expected     = item_s2.seq;
						end else if (seq_gt) begin
							nxt.count      = cnt_n;
							res.feed_event = EV_DOWN;
							if (cnt_n > gap_limit) begin
								res.progressing_up = 1'b1;
								res.packet_action  = ACT_PROCESS;
								nxt.expected       = item_s2.seq_inc;
							end else begin
								nxt.mode             = MODE_RETX;
								nxt.done             = 1'b0;
								res.packet_action    = ACT_QUEUE;
								res.recovery_request = 1'b1;
								res.recovery_first   = cur.expected;
								res.recovery_last    = item_s2.seq_dec;
							end
						end else begin
							res.packet_action = ACT_PROCESS;
							nxt.expected      = item_s2.seq_inc;
						end
					end
					MODE_SNAP: begin
						if (cur.done) begin
							nxt.mode           = MODE_NORMAL;
							nxt.expected       = cur.snap_next;
							res.packet_action  = ACT_QUEUE;
							res.snapshot_image = 1'b1;
							res.feed_event     = EV_UP_INIT;
							res.after_gap      = 1'b1;
						end
					end
					default: begin
						res.packet_action = ACT_QUEUE;
						if (cur.done) begin
							nxt.mode       = MODE_NORMAL;
							nxt.expected   = cur.snap_next;
							res.feed_event = EV_UP;
							res.after_gap  = 1'b1;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem[idx_s2] <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			mem_rd_q <= mem[pop_idx];
			byp_st_q <= nxt;
			item_s2  <= q_item;
		end
		if (adv) begin
			res_s3 <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q  <= '0;
			written_s2 <= 1'b0;
			byp_s2     <= 1'b0;
			vld_s2     <= 1'b0;
			vld_s3     <= 1'b0;
		end else begin
			if (wr) begin
				written_q[idx_s2] <= 1'b1;
			end
			if (pop) begin
				written_s2 <= written_q[pop_idx];
				byp_s2     <= wr && (idx_s2 == pop_idx);
				vld_s2     <= 1'b1;
			end else if (adv) begin
				vld_s2 <= 1'b0;
			end
			if (adv) begin
				vld_s3 <= 1'b1;
			end else if (out_ready) begin
				vld_s3 <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/feed_group_sequence_gap_tracker_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Feed group sequence gap tracker
// Per-group sequence tracking of a multicast feed with gap recovery events.
// ----------------------------------------------------------------------------
// Path: front-end register, queue, group state read stage, output register.
// Throughput: one beat per cycle while the master side does not stall, with the
// read-modify-write of the group state memory and a bypass for back-to-back beats.
// Reset: asynchronous; per-group written bits clear at once so every group
// reads as init with zero state, and gap_limit returns to 255.
module feed_group_sequence_gap_tracker_top #(
	parameter int NUM_GROUPS = fgst_pkg::NUM_GROUPS_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire [fgst_pkg::LIMIT_W-1:0]    cfg_wdata,
	input  wire                            s_axis_tvalid,
	output logic                           s_axis_tready,
	// group_id, sequence_req, in_trading_hours, resume_sequence
	input  wire [fgst_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// operation, is_heartbeat
	input  wire [fgst_pkg::IN_USER_W-1:0]  s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  wire                            m_axis_tready,
	// out_group, packet_action, feed_event, progressing_up, back_in_time,
	// recovery_request, recovery_first, recovery_last, snapshot_image, after_gap
	output logic [fgst_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import fgst_pkg::*;

	logic [LIMIT_W-1:0] gap_limit_q;
	in_beat_t           in_beat;
	logic               push;
	logic               q_full;
	logic               q_empty;
	logic               pop;
	item_t              push_item;
	item_t              q_item;
	result_t            res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit_q <= GAP_LIMIT_RESET;
		end else if (cfg_we) begin
			gap_limit_q <= cfg_wdata;
		end
	end

	assign in_beat.operation        = op_t'(s_axis_tuser[0]);
	assign in_beat.is_heartbeat     = s_axis_tuser[1];
	assign in_beat.group_id         = s_axis_tdata[7:0];
	assign in_beat.sequence_req     = s_axis_tdata[71:8];
	assign in_beat.in_trading_hours = s_axis_tdata[72];
	assign in_beat.resume_sequence  = s_axis_tdata[136:73];

	fgst_front #(
		.NUM_GROUPS(NUM_GROUPS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_beat   (in_beat),
		.push      (push),
		.q_full    (q_full),
		.push_item (push_item)
	);

	fgst_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.pop_item  (q_item)
	);

	fgst_back #(
		.NUM_GROUPS(NUM_GROUPS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.gap_limit  (gap_limit_q),
		.q_empty    (q_empty),
		.q_item     (q_item),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_result (res)
	);

	assign m_axis_tdata = {6'b0, res.after_gap, res.snapshot_image, res.recovery_last,
		res.recovery_first, res.recovery_request, res.back_in_time, res.progressing_up,
		res.feed_event, res.packet_action, res.out_group};

endmodule
`default_nettype wire
